>>> rtl/mwee_pkg.sv
// Shared constants for the Microwire serial EEPROM master.
package mwee_pkg;

  // Default geometry of the attached part
  localparam int unsigned ADDRESS_BITS_DEF = 8;
  localparam int unsigned DATA_BITS_DEF    = 16;
  localparam int unsigned END_CLOCKS_DEF   = 5;

  // Fixed port widths
  localparam int unsigned ADDR_PORT_W = 8;
  localparam int unsigned DATA_PORT_W = 16;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned INTERVAL_W  = 16;
  localparam int unsigned LIMIT_W     = 8;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_POLL_INTERVAL = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_POLL_LIMIT    = 1'd1;

  // Register reset values
  localparam logic [INTERVAL_W-1:0] POLL_INTERVAL_RST = 16'd1000;
  localparam logic [LIMIT_W-1:0]    POLL_LIMIT_RST    = 8'd100;

  // Command codes on the input channel
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_RESET = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // Frame codes: the four bits just below the start bit (two opcode bits and the top two address bits)
  localparam logic [3:0] CODE_READ  = 4'h8;
  localparam logic [3:0] CODE_WRITE = 4'h4;
  localparam logic [3:0] CODE_EWEN  = 4'h3;
  localparam logic [3:0] CODE_EWDS  = 4'h0;

  // Sections of a write command
  localparam logic [1:0] STG_ENABLE  = 2'd0;
  localparam logic [1:0] STG_WRITE   = 2'd1;
  localparam logic [1:0] STG_POLL    = 2'd2;
  localparam logic [1:0] STG_DISABLE = 2'd3;

endpackage

>>> rtl/microwire_eeprom_master.sv
// Microwire serial EEPROM master: tick sequencer with registered result.
//
// Usage: every transaction on the input channel is one tick, one pin-change
// slot of the bit-banged Microwire bus. A tick carries a command offer
// (in_start_req, in_opcode, in_word_address, in_write_data) and the sampled
// EEPROM data line (in_data_out_pin). A command offer is taken only while
// the sequencer is idle; offers while busy, and opcode three, are dropped.
// Every accepted tick yields exactly one result transaction with the pin
// levels after that slot, busy and done flags, the last read word and the
// write timeout flag.
// The result is registered and sits in the output register from the cycle
// after the tick is accepted. Throughput: one tick per cycle while in_stall
// is low; the single output register stage loads in parallel with the state.
// Command length in ticks: a read takes 1 + 5 + 3*(A+3) + 1 + 3*D + 2 + 2*E
// (A address bits, D data bits, E end clocks); a write adds enable, poll and
// disable sections, the poll waiting poll_interval_r ticks before each clock.
// Stall: in_stall rises only while a result is held and out_stall is high,
// so a new tick is taken in the same cycle the held result drains.
// Reset (rst_n low, synchronous): sequencer idle, its pin registers low,
// counters, read word, timeout flag cleared; poll interval 1000, limit 100.
// Configuration writes take effect at once; issue them while idle.
module microwire_eeprom_master #(
  parameter int unsigned ADDRESS_BITS = mwee_pkg::ADDRESS_BITS_DEF,
  parameter int unsigned DATA_BITS    = mwee_pkg::DATA_BITS_DEF,
  parameter int unsigned END_CLOCKS   = mwee_pkg::END_CLOCKS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [mwee_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mwee_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // tick input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_start_req,
  input  logic [1:0]                          in_opcode,
  input  logic [mwee_pkg::ADDR_PORT_W-1:0]    in_word_address,
  input  logic [mwee_pkg::DATA_PORT_W-1:0]    in_write_data,
  input  logic                                in_data_out_pin,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_chip_select,
  output logic                                out_serial_clock,
  output logic                                out_data_in_pin,
  output logic                                out_busy_res,
  output logic                                out_done_res,
  output logic [mwee_pkg::DATA_PORT_W-1:0]    out_read_data,
  output logic                                out_write_timed_out
);
  import mwee_pkg::*;

  localparam int unsigned FRAME_BITS   = ADDRESS_BITS + 3;
  localparam int unsigned RESET_CLOCKS = FRAME_BITS + DATA_BITS + END_CLOCKS;
  localparam int unsigned CNT_W        = $clog2(RESET_CLOCKS + 1);
  localparam int unsigned FIDX_W       = $clog2(FRAME_BITS);
  localparam int unsigned DIDX_W       = $clog2(DATA_BITS);

  typedef enum logic [3:0] {
    PH_IDLE, PH_CMD_PRE, PH_CMD_BITS, PH_CMD_POST, PH_RD_BITS, PH_WR_BITS,
    PH_END, PH_POLL_PRE, PH_POLL_WAIT, PH_POLL_CLK, PH_RST
  } phase_t;

  // configuration registers
  logic [INTERVAL_W-1:0]   poll_interval_r;
  logic [LIMIT_W-1:0]      poll_limit_r;

  // sequencer state
  phase_t                  phase_r, phase_nxt;
  logic [2:0]              sub_r, sub_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [FRAME_BITS-1:0]   frame_r, frame_nxt;
  logic [DATA_BITS-1:0]    shift_r, shift_nxt;
  logic [LIMIT_W-1:0]      poll_cnt_r, poll_cnt_nxt;
  logic [INTERVAL_W-1:0]   interval_r, interval_nxt;
  logic [1:0]              held_r, held_nxt;
  logic [1:0]              stage_r, stage_nxt;
  logic [ADDRESS_BITS-1:0] addr_r, addr_nxt;
  logic                    cs_r, cs_nxt;
  logic                    sk_r, sk_nxt;
  logic                    di_r, di_nxt;
  logic [DATA_BITS-1:0]    read_word_r, read_word_nxt;
  logic                    timed_out_r, timed_out_nxt;
  logic                    busy, done;

  logic                                 accept;
  logic [ADDRESS_BITS+ADDR_PORT_W-1:0]  addr_wide;
  logic [ADDRESS_BITS-1:0]              addr_in;
  logic [FIDX_W-1:0]                    frame_idx;
  logic [DIDX_W-1:0]                    data_idx;
  logic [CNT_W-1:0]                     cnt_dec;

  function automatic logic [FRAME_BITS-1:0] build_frame(
    input logic [3:0]              code,
    input logic [ADDRESS_BITS-1:0] addr
  );
    logic [FRAME_BITS-1:0] f;
    f = (FRAME_BITS'(1) << (ADDRESS_BITS + 2))
      | (FRAME_BITS'(code) << (ADDRESS_BITS - 2))
      | FRAME_BITS'(addr);
    return f;
  endfunction

  // Output register frees in the same cycle it drains
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // Only the low ADDRESS_BITS of the address port reach the bus
  assign addr_wide = {ADDRESS_BITS'(0), in_word_address};
  assign addr_in   = addr_wide[ADDRESS_BITS-1:0];

  assign frame_idx = FIDX_W'(cnt_r - 1'b1);
  assign data_idx  = DIDX_W'(cnt_r - 1'b1);
  assign cnt_dec   = cnt_r - 1'b1;

  always_comb begin
    phase_nxt     = phase_r;
    sub_nxt       = sub_r;
    cnt_nxt       = cnt_r;
    frame_nxt     = frame_r;
    shift_nxt     = shift_r;
    poll_cnt_nxt  = poll_cnt_r;
    interval_nxt  = interval_r;
    held_nxt      = held_r;
    stage_nxt     = stage_r;
    addr_nxt      = addr_r;
    cs_nxt        = cs_r;
    sk_nxt        = sk_r;
    di_nxt        = di_r;
    read_word_nxt = read_word_r;
    timed_out_nxt = timed_out_r;
    busy          = 1'b1;
    done          = 1'b0;

    unique case (phase_r)
      PH_IDLE: begin
        busy = 1'b0;
        if (in_start_req && in_opcode != OP_NONE) begin
          busy      = 1'b1;
          held_nxt  = in_opcode;
          stage_nxt = STG_ENABLE;
          sub_nxt   = 3'd0;
          if (in_opcode == OP_READ) begin
            frame_nxt = build_frame(CODE_READ, addr_in);
            cnt_nxt   = CNT_W'(FRAME_BITS);
            phase_nxt = PH_CMD_PRE;
          end else if (in_opcode == OP_WRITE) begin
            // enable writes first; keep the address for the write frame
            shift_nxt     = in_write_data[DATA_BITS-1:0];
            timed_out_nxt = 1'b0;
            addr_nxt      = addr_in;
            frame_nxt     = build_frame(CODE_EWEN, '0);
            cnt_nxt       = CNT_W'(FRAME_BITS);
            phase_nxt     = PH_CMD_PRE;
          end else begin
            cnt_nxt   = CNT_W'(RESET_CLOCKS);
            phase_nxt = PH_RST;
          end
        end
      end

      PH_CMD_PRE: begin
        sub_nxt = sub_r + 3'd1;
        unique case (sub_r)
          3'd0: sk_nxt = 1'b0;
          3'd1: di_nxt = 1'b0;
          3'd2: cs_nxt = 1'b1;
          3'd3: sk_nxt = 1'b1;
          default: begin
            sk_nxt    = 1'b0;
            phase_nxt = PH_CMD_BITS;
            sub_nxt   = 3'd0;
          end
        endcase
      end

      PH_CMD_BITS, PH_WR_BITS: begin
        unique case (sub_r)
          3'd0: begin
            di_nxt  = (phase_r == PH_CMD_BITS) ? frame_r[frame_idx] : shift_r[data_idx];
            sub_nxt = 3'd1;
          end
          3'd1: begin
            sk_nxt  = 1'b1;
            sub_nxt = 3'd2;
          end
          default: begin
            sk_nxt  = 1'b0;
            sub_nxt = 3'd0;
            cnt_nxt = cnt_dec;
            if (cnt_r == CNT_W'(1)) begin
              if (phase_r == PH_CMD_BITS) begin
                phase_nxt = PH_CMD_POST;
              end else begin
                phase_nxt = PH_END;
                cnt_nxt   = CNT_W'(END_CLOCKS);
              end
            end
          end
        endcase
      end

      PH_CMD_POST: begin
        di_nxt  = 1'b0;
        sub_nxt = 3'd0;
        cnt_nxt = CNT_W'(DATA_BITS);
        if (held_r == OP_READ) begin
          shift_nxt = '0;
          phase_nxt = PH_RD_BITS;
        end else if (held_r == OP_WRITE && stage_r == STG_WRITE) begin
          phase_nxt = PH_WR_BITS;
        end else begin
          phase_nxt = PH_END;
          cnt_nxt   = CNT_W'(END_CLOCKS);
        end
      end

      PH_RD_BITS: begin
        unique case (sub_r)
          3'd0: begin
            sk_nxt  = 1'b1;
            sub_nxt = 3'd1;
          end
          3'd1: begin
            sk_nxt  = 1'b0;
            sub_nxt = 3'd2;
          end
          default: begin
            // sample the EEPROM data line after the falling edge
            shift_nxt = {shift_r[DATA_BITS-2:0], in_data_out_pin};
            sub_nxt   = 3'd0;
            cnt_nxt   = cnt_dec;
            if (cnt_r == CNT_W'(1)) begin
              read_word_nxt = {shift_r[DATA_BITS-2:0], in_data_out_pin};
              phase_nxt     = PH_END;
              cnt_nxt       = CNT_W'(END_CLOCKS);
            end
          end
        endcase
      end

      PH_END, PH_RST: begin
        unique case (sub_r)
          3'd0: begin
            di_nxt  = 1'b0;
            sub_nxt = 3'd1;
          end
          3'd1: begin
            cs_nxt  = 1'b0;
            sub_nxt = 3'd2;
          end
          3'd2: begin
            sk_nxt  = 1'b1;
            sub_nxt = 3'd3;
          end
          default: begin
            sk_nxt  = 1'b0;
            sub_nxt = 3'd2;
            cnt_nxt = cnt_dec;
            if (cnt_r == CNT_W'(1)) begin
              sub_nxt = 3'd0;
              if (phase_r == PH_RST) begin
                phase_nxt = PH_END;
                cnt_nxt   = CNT_W'(END_CLOCKS);
              end else if (held_r != OP_WRITE || stage_r == STG_DISABLE) begin
                phase_nxt = PH_IDLE;
                done      = 1'b1;
              end else begin
                // advance to the next section of the write command
                stage_nxt = stage_r + 2'd1;
                cnt_nxt   = CNT_W'(FRAME_BITS);
                unique case (stage_r)
                  STG_ENABLE: begin
                    frame_nxt = build_frame(CODE_WRITE, addr_r);
                    phase_nxt = PH_CMD_PRE;
                  end
                  STG_WRITE: phase_nxt = PH_POLL_PRE;
                  default: begin
                    frame_nxt = build_frame(CODE_EWDS, '0);
                    phase_nxt = PH_CMD_PRE;
                  end
                endcase
              end
            end
          end
        endcase
      end

      PH_POLL_PRE: begin
        unique case (sub_r)
          3'd0: begin
            cs_nxt  = 1'b1;
            sub_nxt = 3'd1;
          end
          3'd1: begin
            sk_nxt  = 1'b1;
            sub_nxt = 3'd2;
          end
          default: begin
            sk_nxt       = 1'b0;
            poll_cnt_nxt = poll_limit_r;
            interval_nxt = poll_interval_r;
            sub_nxt      = 3'd0;
            phase_nxt    = (poll_interval_r == '0) ? PH_POLL_CLK : PH_POLL_WAIT;
          end
        endcase
      end

      PH_POLL_WAIT: begin
        interval_nxt = interval_r - 1'b1;
        if (interval_r == INTERVAL_W'(1)) begin
          phase_nxt = PH_POLL_CLK;
          sub_nxt   = 3'd0;
        end
      end

      PH_POLL_CLK: begin
        unique case (sub_r)
          3'd0: begin
            sk_nxt  = 1'b1;
            sub_nxt = 3'd1;
          end
          3'd1: begin
            sk_nxt  = 1'b0;
            sub_nxt = 3'd2;
          end
          default: begin
            sub_nxt = 3'd0;
            if (in_data_out_pin) begin
              phase_nxt = PH_END;
              cnt_nxt   = CNT_W'(END_CLOCKS);
            end else if (poll_cnt_r != '0) begin
              // wait again before the next poll clock
              poll_cnt_nxt = poll_cnt_r - 1'b1;
              interval_nxt = poll_interval_r;
              phase_nxt    = (poll_interval_r == '0) ? PH_POLL_CLK : PH_POLL_WAIT;
            end else begin
              timed_out_nxt = 1'b1;
              phase_nxt     = PH_END;
              cnt_nxt       = CNT_W'(END_CLOCKS);
            end
          end
        endcase
      end

      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_interval_r <= POLL_INTERVAL_RST;
      poll_limit_r    <= POLL_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POLL_INTERVAL: poll_interval_r <= cfg_wdata[INTERVAL_W-1:0];
        CFG_POLL_LIMIT:    poll_limit_r    <= cfg_wdata[LIMIT_W-1:0];
        default:           poll_limit_r    <= poll_limit_r;
      endcase
    end
  end

  // sequencer state: advance one slot per accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      sub_r       <= '0;
      cnt_r       <= '0;
      frame_r     <= '0;
      shift_r     <= '0;
      poll_cnt_r  <= '0;
      interval_r  <= '0;
      held_r      <= '0;
      stage_r     <= '0;
      addr_r      <= '0;
      cs_r        <= 1'b0;
      sk_r        <= 1'b0;
      di_r        <= 1'b0;
      read_word_r <= '0;
      timed_out_r <= 1'b0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      sub_r       <= sub_nxt;
      cnt_r       <= cnt_nxt;
      frame_r     <= frame_nxt;
      shift_r     <= shift_nxt;
      poll_cnt_r  <= poll_cnt_nxt;
      interval_r  <= interval_nxt;
      held_r      <= held_nxt;
      stage_r     <= stage_nxt;
      addr_r      <= addr_nxt;
      cs_r        <= cs_nxt;
      sk_r        <= sk_nxt;
      di_r        <= di_nxt;
      read_word_r <= read_word_nxt;
      timed_out_r <= timed_out_nxt;
    end
  end

  // result register: hold while stalled, drop valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_chip_select     <= cs_nxt;
      out_serial_clock    <= sk_nxt;
      out_data_in_pin     <= di_nxt;
      out_busy_res        <= busy;
      out_done_res        <= done;
      out_read_data       <= DATA_PORT_W'(read_word_nxt);
      out_write_timed_out <= timed_out_nxt;
    end
  end

endmodule
